### hdl/pcf_pkg.sv
// shared constants for the peak hold color fader
package pcf_pkg;

    // default ring size
    localparam int SECTIONS_DEF = 4;

    // divider geometry: numerator, divisor and quotient widths
    localparam int NUM_W = 32;
    localparam int DEN_W = 16;
    localparam int QUO_W = NUM_W - DEN_W;

    // compass direction to ring section: north 0, south 2, east 3, west 1
    localparam logic [1:0] DIR_SEC [4] = '{2'd0, 2'd2, 2'd3, 2'd1};

    // configuration register indexes
    localparam logic [2:0] CFG_THRESHOLD  = 3'd0;
    localparam logic [2:0] CFG_FADE_TICKS = 3'd1;
    localparam logic [2:0] CFG_BASE_RED   = 3'd2;
    localparam logic [2:0] CFG_BASE_GREEN = 3'd3;
    localparam logic [2:0] CFG_BASE_BLUE  = 3'd4;

    // input kinds carried in tuser
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

endpackage

### hdl/pcf_div.sv
// iterative restoring divider, one quotient bit per cycle
module pcf_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [pcf_pkg::NUM_W-1:0]     i_num,
    input  logic [pcf_pkg::DEN_W-1:0]     i_den,
    output logic                          o_done,
    output logic [pcf_pkg::QUO_W-1:0]     o_quo
);

    localparam int CW = $clog2(pcf_pkg::QUO_W);

    logic [pcf_pkg::DEN_W-1:0] r_rem;
    logic [pcf_pkg::QUO_W-1:0] r_quo;
    logic [CW-1:0]             r_cnt;
    logic                      r_busy;
    logic                      r_done;

    logic [pcf_pkg::DEN_W:0]   w_sh;
    logic [pcf_pkg::DEN_W:0]   w_diff;
    logic                      w_ge;

    // numerator high half is below the divisor, so the quotient fits
    assign w_sh   = {r_rem, r_quo[pcf_pkg::QUO_W-1]};
    assign w_ge   = w_sh >= {1'b0, i_den};
    assign w_diff = w_sh - {1'b0, i_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= i_num[pcf_pkg::NUM_W-1:pcf_pkg::QUO_W];
                r_quo  <= i_num[pcf_pkg::QUO_W-1:0];
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= w_ge ? w_diff[pcf_pkg::DEN_W-1:0] : w_sh[pcf_pkg::DEN_W-1:0];
                r_quo <= {r_quo[pcf_pkg::QUO_W-2:0], w_ge};
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(pcf_pkg::QUO_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

### hdl/peak_hold_color_fader_top.sv
// peak hold color fader: section state, fade sequencer and stream ports
// sample: result is offered in the cycle after the word is taken; no new word is taken until it is accepted
// tick: one result per section; an idle section goes from LOAD straight to SEND, a fading section
//   runs MUL1, MUL2, DSTART and DIV per channel (red, green, blue, level) on the shared multiplier and divider
// not ready while a word is in work; config port always ready
// reset (i_rst_n low, synchronous): registers to defaults, sections white, fades stopped
module peak_hold_color_fader_top #(
    parameter int SECTIONS = pcf_pkg::SECTIONS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // direction[1:0], signal_level[17:2], in_red[25:18], in_green[33:26],
    // in_blue[41:34], zero fill [47:42]
    input  logic [47:0] i_s_axis_tdata,
    // op[0]
    input  logic        i_s_axis_tuser,
    // result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // section[1:0], out_red[9:2], out_green[17:10], out_blue[25:18], zero fill [31:26]
    output logic [31:0] o_m_axis_tdata,
    output logic        o_m_axis_tlast,
    // configuration write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int SW = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
    localparam logic [SW-1:0] LAST_SEC = SW'(SECTIONS - 1);
    localparam logic [SW-1:0] DIR_MAP [4] = '{
        SW'(int'(pcf_pkg::DIR_SEC[0]) % SECTIONS),
        SW'(int'(pcf_pkg::DIR_SEC[1]) % SECTIONS),
        SW'(int'(pcf_pkg::DIR_SEC[2]) % SECTIONS),
        SW'(int'(pcf_pkg::DIR_SEC[3]) % SECTIONS)
    };

    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;
    localparam logic [1:0] CH_LEVEL = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MUL1,
        ST_MUL2,
        ST_DSTART,
        ST_DIV,
        ST_SEND
    } t_state;

    // configuration
    logic [15:0] r_thr;
    logic [15:0] r_fade_ticks;
    logic [7:0]  r_base_r;
    logic [7:0]  r_base_g;
    logic [7:0]  r_base_b;

    // section state
    logic [23:0] r_shown       [SECTIONS];
    logic [23:0] r_start_color [SECTIONS];
    logic [15:0] r_start_level [SECTIONS];
    logic [15:0] r_held        [SECTIONS];
    logic [15:0] r_elapsed     [SECTIONS];
    logic        r_active      [SECTIONS];

    // sequencer
    t_state      r_state;
    logic        r_tick;
    logic [SW-1:0] r_sec;
    logic [1:0]  r_ch;
    logic [15:0] r_e;
    logic [15:0] r_e_new;
    logic        r_fin;
    logic [31:0] r_acc;
    logic [7:0]  r_qr;
    logic [7:0]  r_qg;
    logic [31:0] r_out_data;
    logic        r_out_last;

    logic [1:0]  w_dir;
    logic [15:0] w_lvl;
    logic [23:0] w_in_color;
    logic [SW-1:0] w_ssec;
    logic        w_hit;
    logic [15:0] w_t;
    logic [15:0] w_e_inc;
    logic [15:0] w_ma;
    logic [15:0] w_mb;
    logic [15:0] w_mul_x;
    logic [15:0] w_mul_y;
    logic [31:0] w_prod;
    logic        w_div_done;
    logic [15:0] w_quo;
    logic [23:0] w_fade_color;
    logic        w_in_acc;
    logic        w_out_acc;

    assign w_dir      = i_s_axis_tdata[1:0];
    assign w_lvl      = i_s_axis_tdata[17:2];
    assign w_in_color = {i_s_axis_tdata[25:18], i_s_axis_tdata[33:26], i_s_axis_tdata[41:34]};
    assign w_ssec     = DIR_MAP[w_dir];
    assign w_hit      = (w_lvl > r_thr) && (w_lvl > r_held[w_ssec]);

    // zero fade length behaves as one tick
    assign w_t     = (r_fade_ticks == 16'd0) ? 16'd1 : r_fade_ticks;
    assign w_e_inc = (r_elapsed[r_sec] != 16'hffff) ? r_elapsed[r_sec] + 16'd1
                                                     : r_elapsed[r_sec];

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = (r_state == ST_SEND);
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;
    assign o_cfg_ready     = 1'b1;

    assign w_in_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_acc = o_m_axis_tvalid && i_m_axis_tready;

    // blend operands: start value against baseline, level fades toward zero
    always_comb begin
        case (r_ch)
            CH_RED: begin
                w_ma = {8'd0, r_start_color[r_sec][23:16]};
                w_mb = {8'd0, r_base_r};
            end
            CH_GREEN: begin
                w_ma = {8'd0, r_start_color[r_sec][15:8]};
                w_mb = {8'd0, r_base_g};
            end
            CH_BLUE: begin
                w_ma = {8'd0, r_start_color[r_sec][7:0]};
                w_mb = {8'd0, r_base_b};
            end
            default: begin
                w_ma = r_start_level[r_sec];
                w_mb = 16'd0;
            end
        endcase
    end

    // shared multiplier: start*(t-e) first, then base*e accumulated
    assign w_mul_x = (r_state == ST_MUL1) ? w_ma : w_mb;
    assign w_mul_y = (r_state == ST_MUL1) ? (w_t - r_e) : r_e;
    assign w_prod  = 32'(w_mul_x) * 32'(w_mul_y);

    assign w_fade_color = {r_qr, r_qg, w_quo[7:0]};

    pcf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == ST_DSTART),
        .i_num   (r_acc),
        .i_den   (w_t),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr        <= 16'd655;
            r_fade_ticks <= 16'd2000;
            r_base_r     <= 8'd255;
            r_base_g     <= 8'd255;
            r_base_b     <= 8'd255;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                pcf_pkg::CFG_THRESHOLD:  r_thr        <= i_cfg_data;
                pcf_pkg::CFG_FADE_TICKS: r_fade_ticks <= i_cfg_data;
                pcf_pkg::CFG_BASE_RED:   r_base_r     <= i_cfg_data[7:0];
                pcf_pkg::CFG_BASE_GREEN: r_base_g     <= i_cfg_data[7:0];
                pcf_pkg::CFG_BASE_BLUE:  r_base_b     <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_tick     <= 1'b0;
            r_sec      <= '0;
            r_ch       <= CH_RED;
            r_out_last <= 1'b0;
            for (int i = 0; i < SECTIONS; i++) begin
                r_shown[i]       <= 24'hffffff;
                r_start_color[i] <= 24'hffffff;
                r_start_level[i] <= 16'd0;
                r_held[i]        <= 16'd0;
                r_elapsed[i]     <= 16'd0;
                r_active[i]      <= 1'b0;
            end
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        if (i_s_axis_tuser == pcf_pkg::OP_TICK) begin
                            r_tick  <= 1'b1;
                            r_sec   <= '0;
                            r_state <= ST_LOAD;
                        end else begin
                            r_tick     <= 1'b0;
                            r_out_last <= 1'b1;
                            if (w_hit) begin
                                r_shown[w_ssec]       <= w_in_color;
                                r_start_color[w_ssec] <= w_in_color;
                                r_start_level[w_ssec] <= w_lvl;
                                r_elapsed[w_ssec]     <= 16'd0;
                                r_active[w_ssec]      <= 1'b1;
                                r_out_data <= {6'd0, w_in_color[7:0], w_in_color[15:8],
                                               w_in_color[23:16], 2'(w_ssec)};
                            end else begin
                                r_out_data <= {6'd0, r_shown[w_ssec][7:0],
                                               r_shown[w_ssec][15:8],
                                               r_shown[w_ssec][23:16], 2'(w_ssec)};
                            end
                            r_state <= ST_SEND;
                        end
                    end
                end
                ST_LOAD: begin
                    r_out_last <= (r_sec == LAST_SEC);
                    if (r_active[r_sec]) begin
                        r_e_new <= w_e_inc;
                        r_e     <= (w_e_inc > w_t) ? w_t : w_e_inc;
                        r_fin   <= (w_e_inc >= w_t);
                        r_ch    <= CH_RED;
                        r_state <= ST_MUL1;
                    end else begin
                        r_out_data <= {6'd0, r_shown[r_sec][7:0], r_shown[r_sec][15:8],
                                       r_shown[r_sec][23:16], 2'(r_sec)};
                        r_state    <= ST_SEND;
                    end
                end
                ST_MUL1: begin
                    r_acc   <= w_prod;
                    r_state <= ST_MUL2;
                end
                ST_MUL2: begin
                    r_acc   <= r_acc + w_prod;
                    r_state <= ST_DSTART;
                end
                ST_DSTART: begin
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    if (w_div_done) begin
                        case (r_ch)
                            CH_RED: begin
                                r_qr    <= w_quo[7:0];
                                r_ch    <= CH_GREEN;
                                r_state <= ST_MUL1;
                            end
                            CH_GREEN: begin
                                r_qg    <= w_quo[7:0];
                                r_ch    <= CH_BLUE;
                                r_state <= ST_MUL1;
                            end
                            CH_BLUE: begin
                                r_shown[r_sec] <= w_fade_color;
                                r_out_data <= {6'd0, w_quo[7:0], r_qg, r_qr, 2'(r_sec)};
                                r_ch    <= CH_LEVEL;
                                r_state <= ST_MUL1;
                            end
                            default: begin
                                // fade finished: stop timer and drop the held level
                                if (r_fin) begin
                                    r_active[r_sec]  <= 1'b0;
                                    r_elapsed[r_sec] <= 16'd0;
                                    r_held[r_sec]    <= 16'd0;
                                end else begin
                                    r_elapsed[r_sec] <= r_e_new;
                                    r_held[r_sec]    <= w_quo;
                                end
                                r_state <= ST_SEND;
                            end
                        endcase
                    end
                end
                ST_SEND: begin
                    if (w_out_acc) begin
                        if (r_tick && (r_sec != LAST_SEC)) begin
                            r_sec   <= r_sec + SW'(1);
                            r_state <= ST_LOAD;
                        end else begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

### sim/peak_hold_color_fader_top_test.sv
// testbench for the peak hold color fader: directed table, then random predicted phases
`timescale 1ns / 1ps

module peak_hold_color_fader_top_test;

    localparam int NSEC = 4;
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 54;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES = 12;
    localparam int END_CYCLES = 40;
    localparam int STALL_LIMIT = 4000;

    localparam logic [1:0] DIR_NORTH = 2'd0;
    localparam logic [1:0] DIR_SOUTH = 2'd1;
    localparam logic [1:0] DIR_EAST  = 2'd2;
    localparam logic [1:0] DIR_WEST  = 2'd3;
    // compass direction to ring section
    localparam logic [1:0] SECTION_OF_DIR [4] = '{2'd0, 2'd2, 2'd3, 2'd1};

    typedef enum logic {ROW_ITEM, ROW_REG} t_row_kind;

    typedef struct {
        t_row_kind   kind;
        logic [2:0]  reg_idx;
        logic [15:0] reg_val;
        logic        op;
        logic [1:0]  dir;
        logic [15:0] level;
        logic [23:0] rgb;
        bit          typed;
        logic [23:0] want_rgb;
    } t_stim_row;

    typedef struct packed {
        logic [1:0] section;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } t_shade;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [47:0] i_s_axis_tdata = '0;
    logic        i_s_axis_tuser = pcf_pkg::OP_SAMPLE;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [31:0] o_m_axis_tdata;
    logic        o_m_axis_tlast;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = pcf_pkg::CFG_THRESHOLD;
    logic [15:0] i_cfg_data = '0;

    // predictor copy of registers and section state
    logic [15:0] m_thresh;
    logic [15:0] m_fade_len;
    logic [7:0]  m_base_red;
    logic [7:0]  m_base_green;
    logic [7:0]  m_base_blue;
    logic [23:0] shown_rgb [NSEC];
    logic [23:0] origin_rgb [NSEC];
    logic [15:0] origin_lvl [NSEC];
    logic [15:0] held_lvl [NSEC];
    logic [15:0] elapsed [NSEC];
    logic        fading [NSEC];

    t_shade    due_shades[$];
    t_stim_row stim_rows[$];

    int  mismatches = 0;
    int  quiet_cycles = 0;
    int  tx_gap_pct = 20;
    int  rx_stall_pct = 5;
    int  cur_phase = -1;
    bit  hold_off_done = 1'b0;

    peak_hold_color_fader_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // floor((from*(t-e) + to*e) / t), exact
    function automatic logic [15:0] fade_mix(input logic [15:0] from, input logic [15:0] to,
                                             input logic [15:0] e, input logic [16:0] t);
        logic [47:0] num;
        num = 48'(from) * 48'(t - 17'(e)) + 48'(to) * 48'(e);
        return 16'(num / 48'(t));
    endfunction

    function automatic t_shade shade_of(input logic [1:0] s, input logic last);
        t_shade sh;
        sh.section = s;
        sh.red = shown_rgb[s][23:16];
        sh.green = shown_rgb[s][15:8];
        sh.blue = shown_rgb[s][7:0];
        sh.last = last;
        return sh;
    endfunction

    task automatic fader_reset();
        m_thresh = 16'd655;
        m_fade_len = 16'd2000;
        m_base_red = 8'hff;
        m_base_green = 8'hff;
        m_base_blue = 8'hff;
        for (int k = 0; k < NSEC; k++) begin
            shown_rgb[k] = 24'hffffff;
            origin_rgb[k] = 24'hffffff;
            origin_lvl[k] = '0;
            held_lvl[k] = '0;
            elapsed[k] = '0;
            fading[k] = 1'b0;
        end
    endtask

    // works out the result words of one accepted item and queues them
    task automatic fade_predict(input logic op, input logic [1:0] dir, input logic [15:0] level,
                                input logic [23:0] rgb);
        logic [1:0]  s;
        logic [16:0] t;
        logic [15:0] e;
        logic [15:0] r;
        logic [15:0] g;
        logic [15:0] b;
        if (op == pcf_pkg::OP_SAMPLE) begin
            s = SECTION_OF_DIR[dir];
            if (level > m_thresh && level > held_lvl[s]) begin
                shown_rgb[s] = rgb;
                origin_rgb[s] = rgb;
                origin_lvl[s] = level;
                elapsed[s] = '0;
                fading[s] = 1'b1;
            end
            due_shades.insert(due_shades.size(), shade_of(s, 1'b1));
        end else begin
            t = (m_fade_len == 16'd0) ? 17'd1 : {1'b0, m_fade_len};
            for (int k = 0; k < NSEC; k++) begin
                if (fading[k]) begin
                    if (elapsed[k] != 16'hffff)
                        elapsed[k] = elapsed[k] + 16'd1;
                    // a shortened fade clamps to the end
                    e = (17'(elapsed[k]) > t) ? t[15:0] : elapsed[k];
                    r = fade_mix({8'd0, origin_rgb[k][23:16]}, {8'd0, m_base_red}, e, t);
                    g = fade_mix({8'd0, origin_rgb[k][15:8]}, {8'd0, m_base_green}, e, t);
                    b = fade_mix({8'd0, origin_rgb[k][7:0]}, {8'd0, m_base_blue}, e, t);
                    shown_rgb[k] = {r[7:0], g[7:0], b[7:0]};
                    held_lvl[k] = fade_mix(origin_lvl[k], 16'd0, e, t);
                    if (17'(e) >= t) begin
                        fading[k] = 1'b0;
                        elapsed[k] = '0;
                        held_lvl[k] = '0;
                    end
                end
                due_shades.insert(due_shades.size(), shade_of(2'(k), k == NSEC - 1));
            end
        end
    endtask

    function automatic t_stim_row item_row(input logic op, input logic [1:0] dir,
                                           input logic [15:0] level, input logic [23:0] rgb,
                                           input bit typed, input logic [23:0] want_rgb);
        t_stim_row row;
        row.kind = ROW_ITEM;
        row.reg_idx = pcf_pkg::CFG_THRESHOLD;
        row.reg_val = '0;
        row.op = op;
        row.dir = dir;
        row.level = level;
        row.rgb = rgb;
        row.typed = typed;
        row.want_rgb = want_rgb;
        return row;
    endfunction

    function automatic t_stim_row reg_row(input logic [2:0] idx, input logic [15:0] val);
        t_stim_row row;
        row = item_row(pcf_pkg::OP_SAMPLE, DIR_NORTH, '0, '0, 1'b0, '0);
        row.kind = ROW_REG;
        row.reg_idx = idx;
        row.reg_val = val;
        return row;
    endfunction

    function automatic void add_item(input logic op, input logic [1:0] dir,
                                     input logic [15:0] level, input logic [23:0] rgb,
                                     input bit typed, input logic [23:0] want_rgb);
        stim_rows.insert(stim_rows.size(), item_row(op, dir, level, rgb, typed, want_rgb));
    endfunction

    function automatic void add_reg(input logic [2:0] idx, input logic [15:0] val);
        stim_rows.insert(stim_rows.size(), reg_row(idx, val));
    endfunction

    // leaves i_cfg_valid high so back to back writes need one assignment per step
    task automatic reg_write(input logic [2:0] idx, input logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            pcf_pkg::CFG_THRESHOLD:  m_thresh = val;
            pcf_pkg::CFG_FADE_TICKS: m_fade_len = val;
            pcf_pkg::CFG_BASE_RED:   m_base_red = val[7:0];
            pcf_pkg::CFG_BASE_GREEN: m_base_green = val[7:0];
            pcf_pkg::CFG_BASE_BLUE:  m_base_blue = val[7:0];
            default: ;
        endcase
    endtask

    task automatic send_item(input t_stim_row row);
        t_shade sh;
        if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser <= row.op;
        i_s_axis_tdata <= {6'd0, row.rgb[7:0], row.rgb[15:8], row.rgb[23:16], row.level, row.dir};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        fade_predict(row.op, row.dir, row.level, row.rgb);
        if (row.typed) begin
            sh = due_shades.pop_back();
            sh.red = row.want_rgb[23:16];
            sh.green = row.want_rgb[15:8];
            sh.blue = row.want_rgb[7:0];
            due_shades.insert(due_shades.size(), sh);
        end
    endtask

    // wait until every expected word is in, then let the block go quiet
    task automatic settle();
        i_s_axis_tvalid <= 1'b0;
        while (due_shades.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // result checker and watchdog
    always @(posedge i_clk) begin
        t_shade want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (due_shades.size() == 0) begin
                $error("result word with nothing expected: tdata %h tlast %b",
                       o_m_axis_tdata, o_m_axis_tlast);
                mismatches++;
            end else begin
                want = due_shades.pop_front();
                if (o_m_axis_tdata[1:0] !== want.section) begin
                    $error("section: expected %0d, got %0d", want.section, o_m_axis_tdata[1:0]);
                    mismatches++;
                end
                if (o_m_axis_tdata[9:2] !== want.red) begin
                    $error("out_red: expected %0d, got %0d", want.red, o_m_axis_tdata[9:2]);
                    mismatches++;
                end
                if (o_m_axis_tdata[17:10] !== want.green) begin
                    $error("out_green: expected %0d, got %0d", want.green, o_m_axis_tdata[17:10]);
                    mismatches++;
                end
                if (o_m_axis_tdata[25:18] !== want.blue) begin
                    $error("out_blue: expected %0d, got %0d", want.blue, o_m_axis_tdata[25:18]);
                    mismatches++;
                end
                if (o_m_axis_tlast !== want.last) begin
                    $error("last_of_run: expected %0d, got %0d", want.last, o_m_axis_tlast);
                    mismatches++;
                end
            end
        end
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("peak_hold_color_fader_top test failed");
            $finish;
        end else begin
            quiet_cycles++;
        end
    end

    // result side: random stalls plus one long hold-off in the second phase
    initial begin
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (cur_phase == 1 && !hold_off_done) begin
                hold_off_done = 1'b1;
                i_m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                i_m_axis_tready <= 1'b1;
            end else if (rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct) begin
                i_m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
                i_m_axis_tready <= 1'b1;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        t_stim_row   row;
        bit          in_regs;
        int          tick_pct;
        logic [1:0]  s;
        logic [15:0] val;

        fader_reset();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // below and at threshold leave the sections white
        add_item(pcf_pkg::OP_SAMPLE, DIR_NORTH, 16'd0, 24'h000000, 1'b1, 24'hffffff);
        add_item(pcf_pkg::OP_SAMPLE, DIR_SOUTH, 16'd655, 24'h000000, 1'b1, 24'hffffff);
        add_item(pcf_pkg::OP_SAMPLE, DIR_EAST, 16'd656, 24'h123456, 1'b1, 24'h123456);
        add_item(pcf_pkg::OP_SAMPLE, DIR_WEST, 16'hffff, 24'h000000, 1'b1, 24'h000000);
        // held level stays zero until the next tick, so this latches again
        add_item(pcf_pkg::OP_SAMPLE, DIR_WEST, 16'hffff, 24'ha5a55a, 1'b1, 24'ha5a55a);
        add_item(pcf_pkg::OP_TICK, DIR_NORTH, 16'hffff, 24'hffffff, 1'b0, '0);
        add_item(pcf_pkg::OP_SAMPLE, DIR_WEST, 16'hffff, 24'h000000, 1'b1, 24'h000000);
        add_item(pcf_pkg::OP_SAMPLE, DIR_EAST, 16'd100, 24'hffffff, 1'b0, '0);
        add_reg(pcf_pkg::CFG_FADE_TICKS, 16'd1);
        add_item(pcf_pkg::OP_TICK, DIR_SOUTH, 16'd0, 24'h000000, 1'b0, '0);
        add_reg(pcf_pkg::CFG_BASE_RED, 16'd0);
        add_reg(pcf_pkg::CFG_BASE_GREEN, 16'd128);
        add_reg(pcf_pkg::CFG_BASE_BLUE, 16'd255);
        add_reg(pcf_pkg::CFG_THRESHOLD, 16'd0);
        add_item(pcf_pkg::OP_SAMPLE, DIR_NORTH, 16'd1, 24'h808080, 1'b1, 24'h808080);
        add_item(pcf_pkg::OP_TICK, DIR_EAST, 16'h5555, 24'haaaaaa, 1'b0, '0);
        add_reg(pcf_pkg::CFG_THRESHOLD, 16'hffff);
        add_item(pcf_pkg::OP_SAMPLE, DIR_SOUTH, 16'hffff, 24'h000000, 1'b0, '0);
        // zero fade length acts as one tick
        add_reg(pcf_pkg::CFG_THRESHOLD, 16'd0);
        add_reg(pcf_pkg::CFG_FADE_TICKS, 16'd0);
        add_item(pcf_pkg::OP_SAMPLE, DIR_SOUTH, 16'd500, 24'h010203, 1'b1, 24'h010203);
        add_item(pcf_pkg::OP_TICK, DIR_WEST, 16'haaaa, 24'h555555, 1'b0, '0);
        add_reg(pcf_pkg::CFG_FADE_TICKS, 16'hffff);
        add_reg(pcf_pkg::CFG_BASE_RED, 16'd255);
        add_reg(pcf_pkg::CFG_BASE_GREEN, 16'd0);
        add_reg(pcf_pkg::CFG_BASE_BLUE, 16'd0);
        add_item(pcf_pkg::OP_SAMPLE, DIR_EAST, 16'hffff, 24'hfefdfc, 1'b1, 24'hfefdfc);
        add_item(pcf_pkg::OP_TICK, DIR_NORTH, 16'd0, 24'h000000, 1'b0, '0);
        add_item(pcf_pkg::OP_TICK, DIR_NORTH, 16'd0, 24'h000000, 1'b0, '0);
        // fade length drops below the running count: ends on the next tick
        add_reg(pcf_pkg::CFG_FADE_TICKS, 16'd1);
        add_item(pcf_pkg::OP_TICK, DIR_EAST, 16'd0, 24'h000000, 1'b0, '0);
        add_item(pcf_pkg::OP_TICK, DIR_WEST, 16'd0, 24'h000000, 1'b0, '0);

        in_regs = 1'b0;
        foreach (stim_rows[i]) begin
            if (stim_rows[i].kind == ROW_REG) begin
                if (!in_regs)
                    settle();
                in_regs = 1'b1;
                reg_write(stim_rows[i].reg_idx, stim_rows[i].reg_val);
            end else begin
                if (in_regs)
                    i_cfg_valid <= 1'b0;
                in_regs = 1'b0;
                send_item(stim_rows[i]);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            settle();
            tx_gap_pct = $urandom_range(0, 30);
            rx_stall_pct = (p % 3 == 0) ? 0 : $urandom_range(2, 12);
            tick_pct = $urandom_range(20, 45);
            if (p == 1)
                tx_gap_pct = 0;
            if (p == PHASES - 1) begin
                tx_gap_pct = 0;
                rx_stall_pct = 0;
            end

            case ($urandom_range(0, 5))
                0: val = 16'd0;
                1: val = 16'hffff;
                2: val = 16'($urandom);
                default: val = 16'($urandom_range(0, 4000));
            endcase
            reg_write(pcf_pkg::CFG_THRESHOLD, val);
            case ($urandom_range(0, 9))
                0: val = 16'd0;
                1: val = 16'hffff;
                2: val = 16'($urandom);
                3, 4: val = 16'($urandom_range(1, 3));
                default: val = 16'($urandom_range(4, 24));
            endcase
            reg_write(pcf_pkg::CFG_FADE_TICKS, val);
            reg_write(pcf_pkg::CFG_BASE_RED, 16'($urandom_range(0, 255)));
            reg_write(pcf_pkg::CFG_BASE_GREEN, ($urandom_range(0, 3) == 0) ? 16'd0 : 16'd255);
            reg_write(pcf_pkg::CFG_BASE_BLUE, 16'($urandom_range(0, 255)));
            i_cfg_valid <= 1'b0;

            // the result side stalls long in the second phase while words keep coming
            cur_phase = p;

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                row = item_row(pcf_pkg::OP_SAMPLE, 2'($urandom_range(0, 3)), 16'($urandom),
                               24'($urandom), 1'b0, '0);
                if ($urandom_range(0, 99) < tick_pct)
                    row.op = pcf_pkg::OP_TICK;
                s = SECTION_OF_DIR[row.dir];
                // aim levels at the threshold and the held level
                case ($urandom_range(0, 9))
                    0: row.level = 16'd0;
                    1: row.level = 16'hffff;
                    2: row.level = m_thresh;
                    3: row.level = m_thresh + 16'd1;
                    4: row.level = held_lvl[s];
                    5: row.level = held_lvl[s] + 16'd1;
                    default: ;
                endcase
                send_item(row);
            end
        end

        settle();
        repeat (END_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && due_shades.size() == 0)
            $display("peak_hold_color_fader_top test passed");
        else
            $display("peak_hold_color_fader_top test failed");
        $finish;
    end

endmodule
